@@ sv/bcf_pkg.sv @@
// Package for the burst command framer: item codes, burst phases, status codes,
// register indexes, fixed constants and the captured input item type.
// No dependencies; burst_command_framer_core refers to it by scoped names.
package bcf_pkg;

    localparam logic [1:0] KIND_HEADER = 2'd0;
    localparam logic [1:0] KIND_DATA   = 2'd1;
    localparam logic [1:0] KIND_RX     = 2'd2;

    localparam logic [1:0] PH_IDLE  = 2'd0;
    localparam logic [1:0] PH_WRITE = 2'd1;
    localparam logic [1:0] PH_READ  = 2'd2;

    localparam logic [1:0] ST_OK         = 2'd0;
    localparam logic [1:0] ST_COUNT      = 2'd1;
    localparam logic [1:0] ST_UNEXPECTED = 2'd2;

    localparam logic [0:0] REG_SLAVE_SELECT = 1'b0;
    localparam logic [0:0] REG_WIDE_ADDRESS = 1'b1;

    // Bursts longer than this always get a long header.
    localparam int SHORT_WORDS = 8;

    // Most result beats one item can cause.
    localparam int RES_MAX   = 6;
    localparam int RES_IDX_W = $clog2(RES_MAX);

    localparam logic [31:0] SIGN_FILL = 32'hFF00_0000;

    typedef struct packed {
        logic [1:0]  kind;
        logic        read_request;
        logic [1:0]  word_size;
        logic [11:0] word_count;
        logic        auto_increment;
        logic        long_header;
        logic [23:0] start_address;
        logic        sign_extend;
        logic [31:0] data_word;
        logic [7:0]  rx_byte;
    } item_t;

endpackage

@@ sv/bcf_in_if.sv @@
// Input channel of the burst command framer: valid/ready handshake and the
// fields of one input item. No dependencies.
interface bcf_in_if;

    logic        valid;
    logic        ready;
    logic [1:0]  kind;
    logic        read_request;
    logic [1:0]  word_size;
    logic [11:0] word_count;
    logic        auto_increment;
    logic        long_header;
    logic [23:0] start_address;
    logic        sign_extend;
    logic [31:0] data_word;
    logic [7:0]  rx_byte;

    modport source (
        output valid, kind, read_request, word_size, word_count, auto_increment,
               long_header, start_address, sign_extend, data_word, rx_byte,
        input  ready
    );

    modport sink (
        input  valid, kind, read_request, word_size, word_count, auto_increment,
               long_header, start_address, sign_extend, data_word, rx_byte,
        output ready
    );

endinterface

@@ sv/bcf_out_if.sv @@
// Result channel of the burst command framer: valid/ready handshake and the
// fields of one result beat. No dependencies.
interface bcf_out_if;

    logic        valid;
    logic        ready;
    logic [7:0]  tx_byte;
    logic        tx_valid;
    logic [31:0] read_word;
    logic        read_valid;
    logic        last;
    logic [1:0]  status;

    modport source (
        output valid, tx_byte, tx_valid, read_word, read_valid, last, status,
        input  ready
    );

    modport sink (
        input  valid, tx_byte, tx_valid, read_word, read_valid, last, status,
        output ready
    );

endinterface

@@ sv/burst_command_framer_core.sv @@
// Burst command framer: master side of a byte-link burst bus, with APB setup port.
// Depends on bcf_pkg and the channel interfaces bcf_in_if and bcf_out_if.
//
// An accepted item is captured in an input register, worked out combinationally and
// moved into a result buffer that sends one beat per cycle while result.ready is
// high; the next item is taken while the previous one's beats drain. A write data
// word gives word_size+1 beats (four for 32-bit words), a header two to six beats,
// a read byte that completes a word or an error one beat, and a read byte that
// completes no word is absorbed without a beat. The single result port, one beat
// per cycle while result.ready is high, sets the sustained rate; an item passes
// through the input register and the result buffer on its way to its first beat.
module burst_command_framer_core #(
    parameter int MAX_WORDS = 2048
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    bcf_in_if.sink      item,
    bcf_out_if.source   result
);

    localparam int IW = bcf_pkg::RES_IDX_W;

    // Configuration registers
    logic [7:0] slave_select_reg;
    logic       wide_address_reg;
    logic       cfg_write;

    // Input register
    logic          item_valid_reg;
    bcf_pkg::item_t item_reg;

    // Burst state
    logic [1:0]  phase_reg, phase_next;
    logic [11:0] words_left_reg, words_left_next;
    logic [1:0]  size_reg, size_next;
    logic [1:0]  pos_reg, pos_next;
    logic [23:0] asm_reg, asm_next;
    logic        ext_reg, ext_next;

    // Header pieces
    logic [11:0] hdr_words;
    logic [11:0] hdr_c;
    logic        hdr_long;
    logic [7:0]  hdr_cand [bcf_pkg::RES_MAX];
    logic        hdr_en   [bcf_pkg::RES_MAX];
    logic [7:0]  hdr_bytes [bcf_pkg::RES_MAX];
    logic [IW-1:0] hdr_n;

    // Read assembly and word countdown
    logic [31:0] rx_shift;
    logic [31:0] rx_word;
    logic [11:0] wl_dec;
    logic [1:0]  phase_fin;

    // Results of the item in the input register
    logic [IW-1:0] res_cnt;
    logic [7:0]    res_bytes [bcf_pkg::RES_MAX];
    logic          res_tx;
    logic          res_rv;
    logic [31:0]   res_word;
    logic [1:0]    res_status;

    // Result buffer
    logic          buf_valid_reg;
    logic [IW-1:0] buf_idx_reg;
    logic [IW-1:0] buf_cnt_reg;
    logic [7:0]    buf_bytes_reg [bcf_pkg::RES_MAX];
    logic          buf_tx_reg;
    logic          buf_rv_reg;
    logic [31:0]   buf_word_reg;
    logic [1:0]    buf_status_reg;
    logic          buf_last;
    logic          buf_free;
    logic          advance;
    logic          load;

    // ------------------------------------------------------------------
    // Configuration port
    // ------------------------------------------------------------------
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slave_select_reg <= 8'h00;
            wide_address_reg <= 1'b0;
        end
        else if (cfg_write)
        begin
            case (paddr[2:2])
                bcf_pkg::REG_SLAVE_SELECT: slave_select_reg <= pwdata[7:0];
                bcf_pkg::REG_WIDE_ADDRESS: wide_address_reg <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[2:2])
            bcf_pkg::REG_SLAVE_SELECT: prdata = {24'h000000, slave_select_reg};
            bcf_pkg::REG_WIDE_ADDRESS: prdata = {31'h00000000, wide_address_reg};
            default:                   prdata = 32'h00000000;
        endcase
    end

    // ------------------------------------------------------------------
    // Input register
    // ------------------------------------------------------------------
    assign item.ready = !item_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg <= 1'b0;
        end
        else if (item.valid && item.ready)
        begin
            item_valid_reg <= 1'b1;
        end
        else if (advance)
        begin
            item_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (item.valid && item.ready)
        begin
            item_reg <= '{kind:           item.kind,
                          read_request:   item.read_request,
                          word_size:      item.word_size,
                          word_count:     item.word_count,
                          auto_increment: item.auto_increment,
                          long_header:    item.long_header,
                          start_address:  item.start_address,
                          sign_extend:    item.sign_extend,
                          data_word:      item.data_word,
                          rx_byte:        item.rx_byte};
        end
    end

    // ------------------------------------------------------------------
    // Header bytes
    // ------------------------------------------------------------------
    assign hdr_words = (item_reg.word_count == 12'd0) ? 12'(MAX_WORDS) : item_reg.word_count;
    assign hdr_c     = hdr_words - 12'd1;
    assign hdr_long  = item_reg.long_header || (hdr_words > 12'(bcf_pkg::SHORT_WORDS));

    always_comb
    begin
        hdr_cand[0] = slave_select_reg;
        hdr_en[0]   = (slave_select_reg != 8'h00);
        hdr_cand[1] = {hdr_long, item_reg.auto_increment, hdr_c[2:0],
                       item_reg.word_size, item_reg.read_request};
        hdr_en[1]   = 1'b1;
        hdr_cand[2] = hdr_c[10:3];
        hdr_en[2]   = hdr_long;
        hdr_cand[3] = item_reg.start_address[7:0];
        hdr_en[3]   = 1'b1;
        hdr_cand[4] = item_reg.start_address[15:8];
        hdr_en[4]   = hdr_long;
        hdr_cand[5] = item_reg.start_address[23:16];
        hdr_en[5]   = hdr_long && wide_address_reg;
    end

    // Pack the enabled header bytes into consecutive beats.
    always_comb
    begin
        hdr_bytes = '{default: 8'h00};
        hdr_n     = '0;
        for (int i = 0; i < bcf_pkg::RES_MAX; i++)
        begin
            if (hdr_en[i])
            begin
                hdr_bytes[hdr_n] = hdr_cand[i];
                hdr_n            = hdr_n + IW'(1);
            end
        end
    end

    // ------------------------------------------------------------------
    // Read word assembly and word countdown
    // ------------------------------------------------------------------
    assign rx_shift = {24'h000000, item_reg.rx_byte} << {pos_reg, 3'b000};

    always_comb
    begin
        rx_word = {8'h00, asm_reg} | rx_shift;
        if (ext_reg && rx_word[23])
        begin
            rx_word = rx_word | bcf_pkg::SIGN_FILL;
        end
    end

    assign wl_dec    = (words_left_reg != 12'd0) ? words_left_reg - 12'd1 : words_left_reg;
    assign phase_fin = (wl_dec == 12'd0) ? bcf_pkg::PH_IDLE : phase_reg;

    // ------------------------------------------------------------------
    // Item processing
    // ------------------------------------------------------------------
    always_comb
    begin
        res_cnt          = '0;
        res_bytes        = '{default: 8'h00};
        res_tx           = 1'b0;
        res_rv           = 1'b0;
        res_word         = 32'h00000000;
        res_status       = bcf_pkg::ST_OK;
        phase_next       = phase_reg;
        words_left_next  = words_left_reg;
        size_next        = size_reg;
        pos_next         = pos_reg;
        asm_next         = asm_reg;
        ext_next         = ext_reg;

        case (item_reg.kind)
            bcf_pkg::KIND_HEADER:
            begin
                if (phase_reg != bcf_pkg::PH_IDLE)
                begin
                    res_cnt    = IW'(1);
                    res_status = bcf_pkg::ST_UNEXPECTED;
                end
                else if (item_reg.word_count > 12'(MAX_WORDS))
                begin
                    res_cnt    = IW'(1);
                    res_status = bcf_pkg::ST_COUNT;
                end
                else
                begin
                    res_cnt         = hdr_n;
                    res_bytes       = hdr_bytes;
                    res_tx          = 1'b1;
                    phase_next      = item_reg.read_request ? bcf_pkg::PH_READ
                                                            : bcf_pkg::PH_WRITE;
                    words_left_next = hdr_words;
                    size_next       = item_reg.word_size;
                    pos_next        = 2'd0;
                    asm_next        = 24'h000000;
                    ext_next        = item_reg.sign_extend && (item_reg.word_size == 2'd2);
                end
            end
            bcf_pkg::KIND_DATA:
            begin
                if (phase_reg != bcf_pkg::PH_WRITE)
                begin
                    res_cnt    = IW'(1);
                    res_status = bcf_pkg::ST_UNEXPECTED;
                end
                else
                begin
                    res_cnt         = IW'(size_reg) + IW'(1);
                    res_bytes[0]    = item_reg.data_word[7:0];
                    res_bytes[1]    = item_reg.data_word[15:8];
                    res_bytes[2]    = item_reg.data_word[23:16];
                    res_bytes[3]    = item_reg.data_word[31:24];
                    res_tx          = 1'b1;
                    words_left_next = wl_dec;
                    phase_next      = phase_fin;
                end
            end
            bcf_pkg::KIND_RX:
            begin
                if (phase_reg != bcf_pkg::PH_READ)
                begin
                    res_cnt    = IW'(1);
                    res_status = bcf_pkg::ST_UNEXPECTED;
                end
                else if (pos_reg >= size_reg)
                begin
                    res_cnt         = IW'(1);
                    res_rv          = 1'b1;
                    res_word        = rx_word;
                    pos_next        = 2'd0;
                    asm_next        = 24'h000000;
                    words_left_next = wl_dec;
                    phase_next      = phase_fin;
                end
                else
                begin
                    // Partial word: absorb the byte, no beat.
                    asm_next = asm_reg | rx_shift[23:0];
                    pos_next = pos_reg + 2'd1;
                end
            end
            default:
            begin
                res_cnt    = IW'(1);
                res_status = bcf_pkg::ST_UNEXPECTED;
            end
        endcase
    end

    // An item leaves the input register when it has no beats or the buffer
    // is free (or frees up at this edge).
    assign buf_last = (buf_idx_reg == buf_cnt_reg - IW'(1));
    assign buf_free = !buf_valid_reg || (result.ready && buf_last);
    assign advance  = item_valid_reg && ((res_cnt == '0) || buf_free);
    assign load     = advance && (res_cnt != '0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= bcf_pkg::PH_IDLE;
            words_left_reg <= 12'd0;
            size_reg       <= 2'd0;
            pos_reg        <= 2'd0;
            asm_reg        <= 24'h000000;
            ext_reg        <= 1'b0;
        end
        else if (advance)
        begin
            phase_reg      <= phase_next;
            words_left_reg <= words_left_next;
            size_reg       <= size_next;
            pos_reg        <= pos_next;
            asm_reg        <= asm_next;
            ext_reg        <= ext_next;
        end
    end

    // ------------------------------------------------------------------
    // Result buffer
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            buf_valid_reg <= 1'b0;
            buf_idx_reg   <= '0;
            buf_cnt_reg   <= IW'(1);
        end
        else if (load)
        begin
            buf_valid_reg <= 1'b1;
            buf_idx_reg   <= '0;
            buf_cnt_reg   <= res_cnt;
        end
        else if (buf_valid_reg && result.ready)
        begin
            if (buf_last)
            begin
                buf_valid_reg <= 1'b0;
            end
            else
            begin
                buf_idx_reg <= buf_idx_reg + IW'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            buf_bytes_reg  <= res_bytes;
            buf_tx_reg     <= res_tx;
            buf_rv_reg     <= res_rv;
            buf_word_reg   <= res_word;
            buf_status_reg <= res_status;
        end
    end

    assign result.valid      = buf_valid_reg;
    assign result.tx_byte    = buf_tx_reg ? buf_bytes_reg[buf_idx_reg] : 8'h00;
    assign result.tx_valid   = buf_tx_reg;
    assign result.read_word  = buf_word_reg;
    assign result.read_valid = buf_rv_reg;
    assign result.last       = buf_last;
    assign result.status     = buf_status_reg;

`ifndef ASSERT_OFF
    a_buf_index_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        buf_valid_reg |-> (buf_idx_reg < buf_cnt_reg))
        else $error("result buffer index beyond its beat count");

    a_idle_iff_no_words: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == bcf_pkg::PH_IDLE) == (words_left_reg == 12'd0))
        else $error("burst phase and remaining word count disagree");

    a_read_position: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == bcf_pkg::PH_READ) |-> (pos_reg <= size_reg))
        else $error("read byte position passed the word size");

    a_error_beat_alone: assert property (@(posedge clk) disable iff (!rst_n)
        (result.valid && (result.status != bcf_pkg::ST_OK))
            |-> (result.last && !result.tx_valid && !result.read_valid))
        else $error("error beat carries data or is not the last beat");
`endif

endmodule
